/* rtl/ewc_pkg.sv */
// Shared types and constants for the energy-weighted centroid block.
// Holds the input and result beat structs, opcode codes and register indexes.
// No dependencies.
package ewc_pkg;

    localparam int ACC_WIDTH_DEF = 48;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;
    localparam int ESUM_W        = 32;

    typedef enum logic [0:0] {
        OP_DEPOSIT = 1'b0,
        OP_END     = 1'b1
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT = 1'b1;

    typedef struct packed {
        t_opcode            opcode;
        logic [15:0]        deposit_energy;
        logic signed [15:0] pre_x;
        logic signed [15:0] pre_y;
        logic signed [15:0] pre_z;
        logic [15:0]        pre_time;
        logic signed [15:0] post_x;
        logic signed [15:0] post_y;
        logic signed [15:0] post_z;
        logic [15:0]        post_time;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] cent_x;
        logic signed [15:0] cent_y;
        logic signed [15:0] cent_z;
        logic [15:0]        cent_time;
        logic [31:0]        total_energy;
        logic [7:0]         layer_number;
        logic [7:0]         segment_number;
    } t_out_beat;

endpackage

/* rtl/energy_weighted_centroid.sv */
// Energy-weighted centroid of one detector cell's deposits per event.
// Depends on ewc_pkg for beat structs, opcodes and register indexes.
//
// Input channel: i_valid / o_stall / i_data. A beat is taken at a rising edge
// with i_valid high and o_stall low. A deposit beat with nonzero energy is
// accepted and then runs a multiply and a saturating add for each of the
// four coordinates, all through one 17x17 multiplier and one adder.
// A zero-energy deposit is dropped in its accept cycle.
// An end-of-event beat with a nonzero total runs a restoring divider, one
// quotient bit per cycle, once per coordinate, after which the result is
// loaded into the output register. An end-of-event beat with a zero total
// gives no result and is dropped in its accept cycle. o_stall stays high
// while a beat is in work.
// Output channel: o_valid / i_stall / o_data, from a register. A held result
// does not block new deposits; the next result waits until it is taken.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write layer and segment ids.
// Reset (synchronous, active low) clears the ids, all sums and both channels.
module energy_weighted_centroid #(
    parameter int ACC_WIDTH = ewc_pkg::ACC_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  ewc_pkg::t_in_beat              i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output ewc_pkg::t_out_beat             o_data,
    input  logic                           i_cfg_we,
    input  logic [ewc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ewc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int W     = ACC_WIDTH;
    localparam int CNT_W = $clog2(ACC_WIDTH);
    localparam int EW    = ewc_pkg::ESUM_W;
    localparam logic [1:0] LANE_T = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DIV_LOAD,
        S_DIV_STEP,
        S_DIV_END,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [1:0]              r_lane;
    logic [CNT_W-1:0]        r_cnt;
    logic [7:0]              r_layer;
    logic [7:0]              r_segment;
    logic [EW-1:0]           r_esum;
    logic [W-1:0]            r_acc [4];
    logic signed [16:0]      r_mid [4];
    logic [15:0]             r_energy;
    logic signed [33:0]      r_prod;
    logic [EW-1:0]           r_rem;
    logic [W-1:0]            r_quo;
    logic                    r_neg;
    logic [15:0]             r_cent [4];
    logic                    r_out_valid;
    ewc_pkg::t_out_beat      r_out;

    logic                    in_take;
    logic                    out_load;
    logic                    n_out_valid;
    logic [EW:0]             esum_add;
    logic [EW-1:0]           n_esum;
    logic signed [16:0]      sum_x, sum_y, sum_z;
    logic [16:0]             sum_t;
    logic signed [33:0]      n_prod;
    logic [W-1:0]            acc_sel;
    logic [W:0]              acc_ext, prod_ext, acc_add;
    logic [W-1:0]            n_acc;
    logic                    sel_neg;
    logic [W-1:0]            sel_mag;
    logic [EW:0]             div_t;
    logic                    div_ge;
    logic [EW-1:0]           n_rem;
    logic [W-1:0]            n_quo;
    logic [15:0]             n_cent;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign in_take = i_valid && (r_state == S_IDLE);

    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign n_out_valid = out_load || (r_out_valid && i_stall);

    assign esum_add = {1'b0, r_esum} + {{(EW-16+1){1'b0}}, i_data.deposit_energy};
    assign n_esum   = esum_add[EW] ? {EW{1'b1}} : esum_add[EW-1:0];

    assign sum_x = 17'(i_data.pre_x) + 17'(i_data.post_x);
    assign sum_y = 17'(i_data.pre_y) + 17'(i_data.post_y);
    assign sum_z = 17'(i_data.pre_z) + 17'(i_data.post_z);
    assign sum_t = {1'b0, i_data.pre_time} + {1'b0, i_data.post_time};

    assign n_prod = r_mid[r_lane] * $signed({1'b0, r_energy});

    assign acc_sel  = r_acc[r_lane];
    assign acc_ext  = (r_lane == LANE_T) ? {1'b0, acc_sel} : {acc_sel[W-1], acc_sel};
    assign prod_ext = {{(W+1-34){r_prod[33]}}, r_prod};
    assign acc_add  = acc_ext + prod_ext;

    always_comb begin
        if (r_lane == LANE_T) begin
            n_acc = acc_add[W] ? {W{1'b1}} : acc_add[W-1:0];
        end else if (acc_add[W] != acc_add[W-1]) begin
            n_acc = acc_add[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            n_acc = acc_add[W-1:0];
        end
    end

    assign sel_neg = (r_lane != LANE_T) && acc_sel[W-1];
    assign sel_mag = sel_neg ? (~acc_sel + W'(1)) : acc_sel;

    assign div_t  = {r_rem, r_quo[W-1]};
    assign div_ge = (div_t >= {1'b0, r_esum});
    assign n_rem  = div_ge ? EW'(div_t - {1'b0, r_esum}) : div_t[EW-1:0];
    assign n_quo  = {r_quo[W-2:0], div_ge};

    always_comb begin
        if (r_lane == LANE_T) begin
            n_cent = (r_quo > W'(65535)) ? 16'hFFFF : r_quo[15:0];
        end else if (r_neg) begin
            n_cent = (r_quo > W'(32768)) ? 16'h8000 : (~r_quo[15:0] + 16'd1);
        end else begin
            n_cent = (r_quo > W'(32767)) ? 16'h7FFF : r_quo[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lane      <= '0;
            r_cnt       <= '0;
            r_layer     <= '0;
            r_segment   <= '0;
            r_esum      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_acc[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ewc_pkg::CFG_LAYER:   r_layer   <= i_cfg_data;
                    ewc_pkg::CFG_SEGMENT: r_segment <= i_cfg_data;
                    default: ;
                endcase
            end

            r_out_valid <= n_out_valid;

            case (r_state)
                S_IDLE: begin
                    r_lane <= '0;
                    if (in_take) begin
                        if (i_data.opcode == ewc_pkg::OP_DEPOSIT) begin
                            if (i_data.deposit_energy != 16'd0) begin
                                r_energy <= i_data.deposit_energy;
                                r_esum   <= n_esum;
                                r_mid[0] <= sum_x >>> 1;
                                r_mid[1] <= sum_y >>> 1;
                                r_mid[2] <= sum_z >>> 1;
                                r_mid[3] <= $signed({1'b0, sum_t[16:1]});
                                r_state  <= S_MUL;
                            end
                        end else if (r_esum != '0) begin
                            r_state <= S_DIV_LOAD;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc[r_lane] <= n_acc;
                    r_lane        <= r_lane + 2'd1;
                    r_state       <= (r_lane == LANE_T) ? S_IDLE : S_MUL;
                end
                S_DIV_LOAD: begin
                    r_quo   <= sel_mag;
                    r_neg   <= sel_neg;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV_STEP;
                end
                S_DIV_STEP: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(ACC_WIDTH - 1)) begin
                        r_state <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    r_cent[r_lane] <= n_cent;
                    r_lane         <= r_lane + 2'd1;
                    r_state        <= (r_lane == LANE_T) ? S_OUT : S_DIV_LOAD;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out.cent_x         <= $signed(r_cent[0]);
                        r_out.cent_y         <= $signed(r_cent[1]);
                        r_out.cent_z         <= $signed(r_cent[2]);
                        r_out.cent_time      <= r_cent[3];
                        r_out.total_energy   <= r_esum;
                        r_out.layer_number   <= r_layer;
                        r_out.segment_number <= r_segment;
                        r_esum               <= '0;
                        for (int k = 0; k < 4; k++) begin
                            r_acc[k] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/ewc_checker.sv */
// Port-level checks for energy_weighted_centroid, attached by bind.
// Depends on ewc_pkg for the beat structs.
module ewc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input ewc_pkg::t_in_beat              i_data,
    input logic                           o_valid,
    input logic                           i_stall,
    input ewc_pkg::t_out_beat             o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.total_energy != 32'd0)
        else $error("result beat with zero total energy");

    a_deposit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.opcode == ewc_pkg::OP_DEPOSIT
            && i_data.deposit_energy != 16'd0 |=> o_stall)
        else $error("deposit beat did not occupy the datapath");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result appeared while still busy");

endmodule

bind energy_weighted_centroid ewc_checker u_ewc_checker (.*);
